### src/uart_rx_tx_ring_buffers_assert.svh
// assertion macros for the uart ring buffer block
`ifndef UART_RX_TX_RING_BUFFERS_ASSERT_SVH
`define UART_RX_TX_RING_BUFFERS_ASSERT_SVH

// checked only while out of reset
`define URTRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define URTRB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/urtrb_pkg.sv
// shared types and constants for the uart ring buffer block
package urtrb_pkg;

  localparam int RX_DEPTH = 256;
  localparam int TX_DEPTH = 256;
  localparam int RX_AW    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_AW    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int BYTE_W   = 8;

  typedef enum logic [1:0] {
    CMD_RECEIVE  = 2'd0,
    CMD_TX_READY = 2'd1,
    CMD_PUT      = 2'd2,
    CMD_GET      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic              we;
    logic [RX_AW-1:0]  waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [RX_AW-1:0]  raddr;
  } rx_req_t;

  typedef struct packed {
    logic              we;
    logic [TX_AW-1:0]  waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [TX_AW-1:0]  raddr;
  } tx_req_t;

  // per-item result, minus the byte itself
  typedef struct packed {
    logic    data_valid;
    status_t status;
    logic    tx_sel;
    logic    tx_irq;
    logic    rx_nonempty;
  } res_t;

  typedef struct packed {
    logic rx_empty;
    logic rx_full;
    logic tx_empty;
    logic tx_full;
  } flags_t;

endpackage

### src/urtrb_ram.sv
// generic single write port, single registered read port byte memory
module urtrb_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/urtrb_ctrl.sv
// pointer bookkeeping, interrupt enable and per-command decisions
module urtrb_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  urtrb_pkg::cmd_t           cmd,
  input  logic [urtrb_pkg::BYTE_W-1:0] data_in,
  output urtrb_pkg::rx_req_t        rx_req,
  output urtrb_pkg::tx_req_t        tx_req,
  output urtrb_pkg::res_t           res,
  output urtrb_pkg::flags_t         flags
);
  import urtrb_pkg::*;

  logic [RX_AW-1:0] rx_wr_r, rx_wr_nxt, rx_rd_r, rx_rd_nxt;
  logic [TX_AW-1:0] tx_wr_r, tx_wr_nxt, tx_rd_r, tx_rd_nxt;
  logic             tx_irq_r, tx_irq_nxt;
  logic [RX_AW-1:0] rx_wr_inc, rx_rd_inc;
  logic [TX_AW-1:0] tx_wr_inc, tx_rd_inc;
  logic             rx_full, rx_empty, tx_full, tx_empty;

  // wrap at the depth, which need not be a power of two
  assign rx_wr_inc = (rx_wr_r == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_wr_r + 1'b1;
  assign rx_rd_inc = (rx_rd_r == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_rd_r + 1'b1;
  assign tx_wr_inc = (tx_wr_r == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_wr_r + 1'b1;
  assign tx_rd_inc = (tx_rd_r == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_rd_r + 1'b1;

  assign rx_full  = (rx_wr_inc == rx_rd_r);
  assign rx_empty = (rx_wr_r == rx_rd_r);
  assign tx_full  = (tx_wr_inc == tx_rd_r);
  assign tx_empty = (tx_wr_r == tx_rd_r);

  always_comb begin
    rx_wr_nxt  = rx_wr_r;
    rx_rd_nxt  = rx_rd_r;
    tx_wr_nxt  = tx_wr_r;
    tx_rd_nxt  = tx_rd_r;
    tx_irq_nxt = tx_irq_r;
    rx_req.we    = 1'b0;
    rx_req.waddr = rx_wr_r;
    rx_req.wdata = data_in;
    rx_req.re    = 1'b0;
    rx_req.raddr = rx_rd_r;
    tx_req.we    = 1'b0;
    tx_req.waddr = tx_wr_r;
    tx_req.wdata = data_in;
    tx_req.re    = 1'b0;
    tx_req.raddr = tx_rd_r;
    res.data_valid = 1'b0;
    res.status     = ST_OK;
    res.tx_sel     = 1'b0;
    case (cmd)
      CMD_RECEIVE: begin
        if (rx_full) begin
          res.status = ST_FULL;
        end else begin
          rx_req.we = accept;
          rx_wr_nxt = rx_wr_inc;
        end
      end
      CMD_TX_READY: begin
        res.tx_sel = 1'b1;
        if (!tx_empty) begin
          tx_req.re      = accept;
          tx_rd_nxt      = tx_rd_inc;
          res.data_valid = 1'b1;
        end else begin
          tx_irq_nxt = 1'b0;
          res.status = ST_EMPTY;
        end
      end
      CMD_PUT: begin
        if (tx_full) begin
          res.status = ST_FULL;
        end else begin
          tx_req.we  = accept;
          tx_wr_nxt  = tx_wr_inc;
          tx_irq_nxt = 1'b1;
        end
      end
      CMD_GET: begin
        if (!rx_empty) begin
          rx_req.re      = accept;
          rx_rd_nxt      = rx_rd_inc;
          res.data_valid = 1'b1;
        end else begin
          res.status = ST_EMPTY;
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
    res.tx_irq      = tx_irq_nxt;
    res.rx_nonempty = (rx_wr_nxt != rx_rd_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_wr_r  <= '0;
      rx_rd_r  <= '0;
      tx_wr_r  <= '0;
      tx_rd_r  <= '0;
      tx_irq_r <= 1'b0;
    end else if (accept) begin
      rx_wr_r  <= rx_wr_nxt;
      rx_rd_r  <= rx_rd_nxt;
      tx_wr_r  <= tx_wr_nxt;
      tx_rd_r  <= tx_rd_nxt;
      tx_irq_r <= tx_irq_nxt;
    end
  end

  assign flags.rx_empty = rx_empty;
  assign flags.rx_full  = rx_full;
  assign flags.tx_empty = tx_empty;
  assign flags.tx_full  = tx_full;

endmodule

### src/uart_rx_tx_ring_buffers.sv
// top level of the uart receive and transmit ring buffer block
//
// one input item is one event: in_tuser carries the command (received byte,
// transmitter ready, software put, software get) and in_tdata the byte.
// every accepted item yields exactly one result item on the out_ channel.
// the receive and transmit fifos each hold up to depth minus one bytes;
// a byte offered to a full fifo is dropped and reported with status full.
// a transmitter-ready or get on an empty fifo reports status empty, and a
// transmitter-ready on an empty fifo also clears the transmit irq enable.
// the result appears in the cycle after the item is accepted; the byte comes
// out of the fifo memory's registered read port in that same cycle.
// throughput: one item per cycle while out_tready is high; pointers update at
// the accept edge and each memory sees at most one write and one read per cycle.
// stall: while a result waits with out_tready low, in_tready is low and the
// result, including the memory read data, holds steady.
// reset (rst_n low, synchronous) empties both fifos, clears the irq enable
// and drops any pending result; memory contents are not cleared.
module uart_rx_tx_ring_buffers (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_in
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] data_out, [9:8] status,
                                  // [10] tx_irq_enable, [11] rx_nonempty, rest 0
  output logic [0:0]  out_tuser   // [0] data_valid
);
  import urtrb_pkg::*;

  logic              accept;
  cmd_t              cmd;
  rx_req_t           rx_req;
  tx_req_t           tx_req;
  res_t              res;
  flags_t            flags;
  logic [BYTE_W-1:0] rx_q, tx_q, byte_out;

  // result register: valid plus the per-item fields
  logic out_valid_r, out_valid_nxt;
  res_t res_r;

  // take a new item when the result slot is free or being drained
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign cmd       = cmd_t'(in_tuser);

  urtrb_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .cmd     (cmd),
    .data_in (in_tdata),
    .rx_req  (rx_req),
    .tx_req  (tx_req),
    .res     (res),
    .flags   (flags)
  );

  // receive fifo storage
  urtrb_ram #(.DEPTH(RX_DEPTH), .AW(RX_AW), .WIDTH(BYTE_W)) u_rx_ram (
    .clk   (clk),
    .we    (rx_req.we),
    .waddr (rx_req.waddr),
    .wdata (rx_req.wdata),
    .re    (rx_req.re),
    .raddr (rx_req.raddr),
    .rdata (rx_q)
  );

  // transmit fifo storage
  urtrb_ram #(.DEPTH(TX_DEPTH), .AW(TX_AW), .WIDTH(BYTE_W)) u_tx_ram (
    .clk   (clk),
    .we    (tx_req.we),
    .waddr (tx_req.waddr),
    .wdata (tx_req.wdata),
    .re    (tx_req.re),
    .raddr (tx_req.raddr),
    .rdata (tx_q)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  // byte is zero whenever no byte is carried
  assign byte_out = !res_r.data_valid ? '0 : (res_r.tx_sel ? tx_q : rx_q);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, res_r.rx_nonempty, res_r.tx_irq, res_r.status, byte_out};
  assign out_tuser  = res_r.data_valid;

`include "uart_rx_tx_ring_buffers_assert.svh"

  `URTRB_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_tvalid, "result valid after reset")
  `URTRB_ASSERT(a_get_empty, (accept && cmd == CMD_GET && flags.rx_empty) |=> (res_r.status == ST_EMPTY && !res_r.data_valid), "get on empty fifo not reported")
  `URTRB_ASSERT(a_txrdy_empty_irq, (accept && cmd == CMD_TX_READY && flags.tx_empty) |=> !res_r.tx_irq, "irq enable not cleared on empty transmit fifo")
  `URTRB_ASSERT(a_full_no_byte, (accept && cmd == CMD_PUT && flags.tx_full) |=> (res_r.status == ST_FULL && !res_r.data_valid), "put on full fifo not reported")

endmodule
